// File: src/assert_macros.svh
// Assertion macros for the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/svact_pkg.sv
// Package with the codes, constants and state type of the access cost tracker.
package svact_pkg;

  localparam logic [3:0] MODE_REGISTER   = 4'd0;
  localparam logic [3:0] MODE_ADD_ACCESS = 4'd1;
  localparam logic [3:0] MODE_ADD_HOP    = 4'd2;
  localparam logic [3:0] MODE_DROP_ACC   = 4'd3;
  localparam logic [3:0] MODE_DROP_HOP   = 4'd4;
  localparam logic [3:0] MODE_REMOVE     = 4'd5;
  localparam logic [3:0] MODE_ADD_LOAD   = 4'd6;
  localparam logic [3:0] MODE_CHECK      = 4'd7;
  localparam logic [3:0] MODE_SCAN       = 4'd8;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  localparam logic [1:0] CFG_PORT_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IS_PARENT_ROLE = 2'd1;
  localparam logic [1:0] CFG_UP_DIRECTION   = 2'd2;

  localparam int RESULT_LIMIT = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DISPATCH,
    S_CLR,
    S_CNT_RD,
    S_CNT_WR,
    S_SH_RD,
    S_SH_WR,
    S_MUL,
    S_LOAD,
    S_CHECK,
    S_SC_DIR,
    S_SC_ENT,
    S_SC_RD,
    S_SC_MUL,
    S_SC_ACC,
    S_SC_EVAL,
    S_SC_END,
    S_DONE
  } state_t;

endpackage

// File: src/svact_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface svact_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] variable_id;
  logic [1:0]  port_direction;
  logic [31:0] amount;
  logic [31:0] hops_before;
  logic [31:0] accesses_before;
  logic [31:0] hops_after;
  logic [31:0] accesses_after;
  modport source (output valid, mode, variable_id, port_direction, amount, hops_before,
                  accesses_before, hops_after, accesses_after, input ready);
  modport sink (input valid, mode, variable_id, port_direction, amount, hops_before,
                accesses_before, hops_after, accesses_after, output ready);
endinterface

interface svact_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] old_count;
  logic        overloaded;
  logic        migrate_valid;
  logic [1:0]  migrate_direction;
  logic [31:0] migrate_id;
  logic        last;
  modport source (output valid, status, old_count, overloaded, migrate_valid,
                  migrate_direction, migrate_id, last, input ready);
  modport sink (input valid, status, old_count, overloaded, migrate_valid,
                migrate_direction, migrate_id, last, output ready);
endinterface

// File: src/svact_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module svact_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/shared_variable_access_cost_tracker.sv
// Top level of the shared variable access cost tracker.
// The block holds an ordered table of up to NUM_VARS variable ids, each with an
// access and a hop counter per direction, and a 64-bit load accumulator. It works
// on one input transaction at a time and is not ready until that transaction's
// last result has been placed in the output register; a waiting result does not
// keep the next transaction out. Every lookup walks the id memory one held entry
// at a time, and modes 0 to 5 all begin with it; clearing counters on register,
// a counter add and a remove, which moves each later entry down, come after it.
// Add load and check go through the shared 32x32 multiplier. The migration scan
// runs every allowed direction over every entry, all products going through the
// same multiplier; each found result may also wait for the output side.
// There is no clearing pass after reset.
module shared_variable_access_cost_tracker #(
  parameter int NUM_VARS = 32,
  parameter int NUM_DIRS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  svact_in_if.sink            in_ch,
  svact_out_if.source         out_ch
);
  import svact_pkg::*;

  localparam int IW     = $clog2(NUM_VARS + 1);
  localparam int IdAw   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int CntD   = NUM_VARS * NUM_DIRS;
  localparam int CntAw  = (CntD > 1) ? $clog2(CntD) : 1;
  localparam int AddW   = CntAw + 4;
  localparam int DW     = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
  localparam int SdW    = $clog2(NUM_DIRS + 2);
  localparam int TotW   = 32 + $clog2(NUM_DIRS + 1);
  localparam int NresW  = $clog2(RESULT_LIMIT + 1);

  // Control state.
  state_t state_r, state_nxt;
  logic [IW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CntAw-1:0] base_r, base_nxt;
  logic [DW-1:0]    e_r, e_nxt;
  logic [SdW-1:0]   sdir_r, sdir_nxt;
  logic             found_r, found_nxt;
  logic [NUM_VARS-1:0] acc_pres_r, acc_pres_nxt;
  logic [NUM_VARS-1:0] hop_pres_r, hop_pres_nxt;
  logic [63:0]      load_r, load_nxt;
  logic [31:0]      thr_r;
  logic             parent_r;
  logic [1:0]       up_r;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [NresW-1:0] nres_r, nres_nxt;

  // Item operands and working values.
  logic [3:0]       mode_r, mode_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [1:0]       pdir_r, pdir_nxt;
  logic [31:0]      amount_r, amount_nxt;
  logic [31:0]      dh_r, dh_nxt, da_r, da_nxt;
  logic             dhn_r, dhn_nxt, dan_r, dan_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [63:0]      cost_r, cost_nxt;
  logic [TotW-1:0]  total_r, total_nxt;
  logic [31:0]      ad_r, ad_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [31:0]      res_old_r, res_old_nxt;
  logic             res_over_r, res_over_nxt;
  logic [1:0]       pend_dir_r, pend_dir_nxt;
  logic [31:0]      pend_id_r, pend_id_nxt;

  // Output register.
  logic [1:0]  o_status_r, o_status_nxt;
  logic [31:0] o_old_r, o_old_nxt;
  logic        o_over_r, o_over_nxt;
  logic        o_mv_r, o_mv_nxt;
  logic [1:0]  o_md_r, o_md_nxt;
  logic [31:0] o_mid_r, o_mid_nxt;
  logic        o_last_r, o_last_nxt;

  // Memory ports.
  logic             id_we;
  logic [IdAw-1:0]  id_waddr, id_raddr;
  logic [31:0]      id_wdata, id_rdata;
  logic             acc_we, hop_we;
  logic [CntAw-1:0] cnt_waddr, cnt_raddr;
  logic [31:0]      acc_wdata, hop_wdata, acc_rdata, hop_rdata;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Helper values.
  logic             in_acc;
  logic             out_free;
  logic [IdAw-1:0]  idx_a, idx1_a;
  logic [AddW-1:0]  add_dir, add_next;
  logic             dir_ok;
  logic [31:0]      sc_a, sc_h;
  logic [TotW-1:0]  rest;
  logic [TotW:0]    twice_rest;
  logic             hit;
  logic [31:0]      hi_corr;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_a    = idx_r[IdAw-1:0];
  assign idx1_a   = IdAw'(idx_r + IW'(1));
  assign add_dir  = AddW'(base_r) + AddW'(pdir_r) - AddW'(1);
  assign add_next = AddW'(base_r) + AddW'(NUM_DIRS) + AddW'(e_r);
  assign dir_ok   = (pdir_r != 2'd0) && (int'(pdir_r) <= NUM_DIRS);
  assign sc_a     = acc_pres_r[idx_a] ? acc_rdata : 32'd0;
  assign sc_h     = hop_pres_r[idx_a] ? hop_rdata : 32'd0;
  assign rest       = total_r - TotW'(ad_r);
  assign twice_rest = {rest, 1'b0};
  assign hit        = (cost_r > 64'(thr_r)) && ((TotW + 1)'(ad_r) > twice_rest)
                      && (int'(nres_r) < RESULT_LIMIT);
  // Correction to the upper word of the 64-bit product when a difference is negative.
  assign hi_corr  = 32'd0 - (dhn_r ? da_r : 32'd0) - (dan_r ? dh_r : 32'd0);

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.old_count         = o_old_r;
  assign out_ch.overloaded        = o_over_r;
  assign out_ch.migrate_valid     = o_mv_r;
  assign out_ch.migrate_direction = o_md_r;
  assign out_ch.migrate_id        = o_mid_r;
  assign out_ch.last              = o_last_r;

  svact_ram #(.WIDTH(32), .DEPTH(NUM_VARS)) u_id_ram (
    .clk, .we(id_we), .waddr(id_waddr), .wdata(id_wdata), .raddr(id_raddr), .rdata(id_rdata)
  );
  svact_ram #(.WIDTH(32), .DEPTH(CntD)) u_acc_ram (
    .clk, .we(acc_we), .waddr(cnt_waddr), .wdata(acc_wdata), .raddr(cnt_raddr),
    .rdata(acc_rdata)
  );
  svact_ram #(.WIDTH(32), .DEPTH(CntD)) u_hop_ram (
    .clk, .we(hop_we), .waddr(cnt_waddr), .wdata(hop_wdata), .raddr(cnt_raddr),
    .rdata(hop_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode <= MODE_REMOVE) begin
            state_nxt = S_SRCH_RD;
          end else if (in_ch.mode == MODE_ADD_LOAD || in_ch.mode == MODE_CHECK) begin
            state_nxt = S_MUL;
          end else if (in_ch.mode == MODE_SCAN) begin
            state_nxt = S_SC_DIR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SRCH_RD: state_nxt = (idx_r >= count_r) ? S_DISPATCH : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = (id_rdata == id_r) ? S_DISPATCH : S_SRCH_RD;
      S_DISPATCH: begin
        if (mode_r == MODE_REGISTER) begin
          state_nxt = (!found_r && int'(count_r) >= NUM_VARS) ? S_DONE : S_CLR;
        end else if (!found_r) begin
          state_nxt = S_DONE;
        end else if (mode_r == MODE_ADD_ACCESS || mode_r == MODE_ADD_HOP) begin
          if (dir_ok && ((mode_r == MODE_ADD_ACCESS) ? acc_pres_r[idx_a] : hop_pres_r[idx_a]))
          begin
            state_nxt = S_CNT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (mode_r == MODE_REMOVE) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CLR: state_nxt = (int'(e_r) == NUM_DIRS - 1) ? S_DONE : S_CLR;
      S_CNT_RD: state_nxt = S_CNT_WR;
      S_CNT_WR: state_nxt = S_DONE;
      S_SH_RD: state_nxt = (IW'(idx_r + IW'(1)) >= count_r) ? S_DONE : S_SH_WR;
      S_SH_WR: state_nxt = S_SH_RD;
      S_MUL: state_nxt = (mode_r == MODE_CHECK) ? S_CHECK : S_LOAD;
      S_LOAD: state_nxt = S_DONE;
      S_CHECK: state_nxt = S_DONE;
      S_SC_DIR: begin
        if (int'(sdir_r) > NUM_DIRS) begin
          state_nxt = S_SC_END;
        end else if (!parent_r || int'(sdir_r) == int'(up_r)) begin
          state_nxt = S_SC_ENT;
        end
      end
      S_SC_ENT: state_nxt = (idx_r >= count_r) ? S_SC_DIR : S_SC_RD;
      S_SC_RD: state_nxt = S_SC_MUL;
      S_SC_MUL: state_nxt = S_SC_ACC;
      S_SC_ACC: state_nxt = (int'(e_r) == NUM_DIRS - 1) ? S_SC_EVAL : S_SC_RD;
      S_SC_EVAL: begin
        if (!(hit && pend_valid_r) || out_free) begin
          state_nxt = S_SC_ENT;
        end
      end
      S_SC_END: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and output register loads.
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    e_nxt          = e_r;
    sdir_nxt       = sdir_r;
    found_nxt      = found_r;
    acc_pres_nxt   = acc_pres_r;
    hop_pres_nxt   = hop_pres_r;
    load_nxt       = load_r;
    pend_valid_nxt = pend_valid_r;
    nres_nxt       = nres_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    pdir_nxt       = pdir_r;
    amount_nxt     = amount_r;
    dh_nxt         = dh_r;
    da_nxt         = da_r;
    dhn_nxt        = dhn_r;
    dan_nxt        = dan_r;
    prod_nxt       = prod_r;
    cost_nxt       = cost_r;
    total_nxt      = total_r;
    ad_nxt         = ad_r;
    res_status_nxt = res_status_r;
    res_old_nxt    = res_old_r;
    res_over_nxt   = res_over_r;
    pend_dir_nxt   = pend_dir_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_status_nxt   = o_status_r;
    o_old_nxt      = o_old_r;
    o_over_nxt     = o_over_r;
    o_mv_nxt       = o_mv_r;
    o_md_nxt       = o_md_r;
    o_mid_nxt      = o_mid_r;
    o_last_nxt     = o_last_r;
    id_we          = 1'b0;
    id_waddr       = idx_a;
    id_wdata       = id_r;
    id_raddr       = idx_a;
    acc_we         = 1'b0;
    hop_we         = 1'b0;
    cnt_waddr      = add_dir[CntAw-1:0];
    cnt_raddr      = add_dir[CntAw-1:0];
    acc_wdata      = 32'd0;
    hop_wdata      = 32'd0;
    mul_a          = sc_a;
    mul_b          = sc_h;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt       = in_ch.mode;
          id_nxt         = in_ch.variable_id;
          pdir_nxt       = in_ch.port_direction;
          amount_nxt     = in_ch.amount;
          {dhn_nxt, dh_nxt} = {1'b0, in_ch.hops_after} - {1'b0, in_ch.hops_before};
          {dan_nxt, da_nxt} = {1'b0, in_ch.accesses_after} - {1'b0, in_ch.accesses_before};
          idx_nxt        = '0;
          base_nxt       = '0;
          e_nxt          = '0;
          sdir_nxt       = SdW'(1);
          found_nxt      = 1'b0;
          nres_nxt       = '0;
          pend_valid_nxt = 1'b0;
          res_status_nxt = STAT_OK;
          res_old_nxt    = 32'd0;
          res_over_nxt   = 1'b0;
        end
      end
      S_SRCH_CMP: begin
        if (id_rdata == id_r) begin
          found_nxt = 1'b1;
        end else begin
          idx_nxt  = idx_r + IW'(1);
          base_nxt = base_r + CntAw'(NUM_DIRS);
        end
      end
      S_DISPATCH: begin
        if (mode_r == MODE_REGISTER) begin
          if (!found_r && int'(count_r) >= NUM_VARS) begin
            res_status_nxt = STAT_FULL;
          end else begin
            if (!found_r) begin
              id_we     = 1'b1;
              count_nxt = count_r + IW'(1);
            end
            acc_pres_nxt[idx_a] = 1'b1;
            hop_pres_nxt[idx_a] = 1'b1;
          end
        end else if (!found_r) begin
          res_status_nxt = STAT_UNKNOWN;
        end else if (mode_r == MODE_DROP_ACC) begin
          acc_pres_nxt[idx_a] = 1'b0;
        end else if (mode_r == MODE_DROP_HOP) begin
          hop_pres_nxt[idx_a] = 1'b0;
        end
      end
      S_CLR: begin
        cnt_waddr = CntAw'(AddW'(base_r) + AddW'(e_r));
        acc_we    = 1'b1;
        hop_we    = 1'b1;
        e_nxt     = e_r + DW'(1);
      end
      S_CNT_WR: begin
        if (mode_r == MODE_ADD_ACCESS) begin
          res_old_nxt = acc_rdata;
          acc_wdata   = acc_rdata + amount_r;
          acc_we      = 1'b1;
        end else begin
          res_old_nxt = hop_rdata;
          hop_wdata   = hop_rdata + amount_r;
          hop_we      = 1'b1;
        end
      end
      S_SH_RD: begin
        id_raddr  = idx1_a;
        cnt_raddr = add_next[CntAw-1:0];
        if (IW'(idx_r + IW'(1)) >= count_r) begin
          count_nxt = count_r - IW'(1);
        end
      end
      S_SH_WR: begin
        id_raddr  = idx1_a;
        cnt_waddr = CntAw'(AddW'(base_r) + AddW'(e_r));
        acc_wdata = acc_rdata;
        hop_wdata = hop_rdata;
        acc_we    = 1'b1;
        hop_we    = 1'b1;
        if (e_r == '0) begin
          id_we               = 1'b1;
          id_wdata            = id_rdata;
          acc_pres_nxt[idx_a] = acc_pres_r[idx1_a];
          hop_pres_nxt[idx_a] = hop_pres_r[idx1_a];
        end
        if (int'(e_r) == NUM_DIRS - 1) begin
          e_nxt    = '0;
          idx_nxt  = idx_r + IW'(1);
          base_nxt = base_r + CntAw'(NUM_DIRS);
        end else begin
          e_nxt = e_r + DW'(1);
        end
      end
      S_MUL: begin
        if (mode_r == MODE_CHECK) begin
          mul_a = 32'(count_r);
          mul_b = thr_r;
        end else begin
          mul_a = dh_r;
          mul_b = da_r;
        end
        prod_nxt = mul_p;
      end
      S_LOAD: load_nxt = load_r + prod_r + {hi_corr, 32'd0};
      S_CHECK: begin
        res_over_nxt = (load_r > prod_r);
        load_nxt     = 64'd0;
      end
      S_SC_DIR: begin
        idx_nxt  = '0;
        base_nxt = '0;
        if (int'(sdir_r) <= NUM_DIRS && parent_r && int'(sdir_r) != int'(up_r)) begin
          sdir_nxt = sdir_r + SdW'(1);
        end
      end
      S_SC_ENT: begin
        e_nxt     = '0;
        cost_nxt  = 64'd0;
        total_nxt = '0;
        ad_nxt    = 32'd0;
        if (idx_r >= count_r) begin
          sdir_nxt = sdir_r + SdW'(1);
        end
      end
      S_SC_RD: cnt_raddr = CntAw'(AddW'(base_r) + AddW'(e_r));
      S_SC_MUL: begin
        prod_nxt  = mul_p;
        total_nxt = total_r + TotW'(sc_a);
        if (int'(e_r) + 1 == int'(sdir_r)) begin
          ad_nxt = sc_a;
        end
      end
      S_SC_ACC: begin
        cost_nxt = cost_r + prod_r;
        e_nxt    = e_r + DW'(1);
      end
      S_SC_EVAL: begin
        if (!(hit && pend_valid_r) || out_free) begin
          if (hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              o_status_nxt  = STAT_OK;
              o_old_nxt     = 32'd0;
              o_over_nxt    = 1'b0;
              o_mv_nxt      = 1'b1;
              o_md_nxt      = pend_dir_r;
              o_mid_nxt     = pend_id_r;
              o_last_nxt    = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_dir_nxt   = sdir_r[1:0];
            pend_id_nxt    = id_rdata;
            nres_nxt       = nres_r + NresW'(1);
          end
          idx_nxt  = idx_r + IW'(1);
          base_nxt = base_r + CntAw'(NUM_DIRS);
        end
      end
      S_SC_END: load_nxt = 64'd0;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_old_nxt     = res_old_r;
          o_over_nxt    = res_over_r;
          o_mv_nxt      = pend_valid_r;
          o_md_nxt      = pend_valid_r ? pend_dir_r : 2'd0;
          o_mid_nxt     = pend_valid_r ? pend_id_r : 32'd0;
          o_last_nxt    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers, reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      acc_pres_r   <= '0;
      hop_pres_r   <= '0;
      load_r       <= 64'd0;
      thr_r        <= 32'd0;
      parent_r     <= 1'b0;
      up_r         <= 2'd1;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      nres_r       <= '0;
      idx_r        <= '0;
      base_r       <= '0;
      e_r          <= '0;
      sdir_r       <= '0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      acc_pres_r   <= acc_pres_nxt;
      hop_pres_r   <= hop_pres_nxt;
      load_r       <= load_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      nres_r       <= nres_nxt;
      idx_r        <= idx_nxt;
      base_r       <= base_nxt;
      e_r          <= e_nxt;
      sdir_r       <= sdir_nxt;
      found_r      <= found_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PORT_THRESHOLD: thr_r    <= cfg_data;
          CFG_IS_PARENT_ROLE: parent_r <= cfg_data[0];
          CFG_UP_DIRECTION:   up_r     <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    pdir_r       <= pdir_nxt;
    amount_r     <= amount_nxt;
    dh_r         <= dh_nxt;
    da_r         <= da_nxt;
    dhn_r        <= dhn_nxt;
    dan_r        <= dan_nxt;
    prod_r       <= prod_nxt;
    cost_r       <= cost_nxt;
    total_r      <= total_nxt;
    ad_r         <= ad_nxt;
    res_status_r <= res_status_nxt;
    res_old_r    <= res_old_nxt;
    res_over_r   <= res_over_nxt;
    pend_dir_r   <= pend_dir_nxt;
    pend_id_r    <= pend_id_nxt;
    o_status_r   <= o_status_nxt;
    o_old_r      <= o_old_nxt;
    o_over_r     <= o_over_nxt;
    o_mv_r       <= o_mv_nxt;
    o_md_r       <= o_md_nxt;
    o_mid_r      <= o_mid_nxt;
    o_last_r     <= o_last_nxt;
  end

  // Checks on the sequencer.
`include "assert_macros.svh"
  `ASSERT_NXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE, "accepted transaction left idle")
  `ASSERT_IMP(a_count_bound, 1'b1, int'(count_r) <= NUM_VARS, "entry count above table size")
  `ASSERT_IMP(a_nres_bound, 1'b1, int'(nres_r) <= RESULT_LIMIT, "scan result count overflow")
  `ASSERT_NXT(a_done_pushes, state_r == S_DONE && out_free, out_valid_r && o_last_r,
              "final result not loaded")

endmodule
